/* design/bfa_pkg.sv */
// bfa_pkg: shared constants for the bitmap frame allocator
// field widths, command codes, map word geometry and reset values; no dependencies

package bfa_pkg;

    localparam int unsigned NUM_FRAMES_DEF = 1024;
    localparam int unsigned PAGE_SHIFT_DEF = 12;

    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned INDEX_W    = 10;
    localparam int unsigned ADDR_W     = 40;
    localparam int unsigned FRAME_OUT_W = 10;
    localparam int unsigned COUNT_W    = 11;
    localparam int unsigned LIMIT_W    = 11;

    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned BIT_W      = $clog2(WORD_BITS);

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd2;

endpackage

/* design/bitmap_frame_allocator.sv */
// bitmap_frame_allocator: first-fit page frame allocator over a used/free bitmap
// the map lives in one 64-bit wide synchronous memory; depends on bfa_pkg

// After reset the block runs a clearing pass that zeroes every map word, during which
// s_ready stays low; cfg writes are taken as ever. One item is worked at a time.
// Allocate scans the map one 64-bit word per cycle through the single memory read
// port and stops early when a free frame is found. Free and mark do one read-modify-write
// of a single word when the frame is in range. A finished result sits in the output
// register until taken; the next item can be accepted in the cycle after the result has
// moved there. frame_limit is clamped to NUM_FRAMES, and frames set above a lowered
// limit stay set and counted.

module bitmap_frame_allocator #(
    parameter int unsigned NUM_FRAMES = bfa_pkg::NUM_FRAMES_DEF,
    parameter int unsigned PAGE_SHIFT = bfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bfa_pkg::LIMIT_W-1:0]       cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bfa_pkg::FUNC_W-1:0]        s_func,
    input  logic [bfa_pkg::INDEX_W-1:0]       s_frame_index,
    input  logic [bfa_pkg::ADDR_W-1:0]        s_phys_address,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ok,
    output logic [bfa_pkg::FRAME_OUT_W-1:0]   m_frame_out,
    output logic [bfa_pkg::COUNT_W-1:0]       m_frames_used
);
    import bfa_pkg::*;

    localparam int unsigned NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned FRAME_W   = WORD_AW + BIT_W;
    localparam int unsigned CW        = (FRAME_W + 1 > LIMIT_W) ? FRAME_W + 1 : LIMIT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RMW_RD,
        ST_RMW_EV,
        ST_DONE
    } state_t;

    typedef logic [WORD_BITS-1:0] word_t;

    function automatic logic [BIT_W:0] find_low(input word_t v);
        logic [BIT_W:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = {1'b1, BIT_W'(i)};
            end
        end
        return r;
    endfunction

    word_t mem [NUM_WORDS];
    word_t rdata_reg;

    state_t                 state_reg, state_next;
    logic [WORD_AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [LIMIT_W-1:0]     frame_limit_reg, frame_limit_next;
    logic [COUNT_W-1:0]     frames_used_reg, frames_used_next;
    logic [FUNC_W-1:0]      op_reg, op_next;
    logic [FRAME_W-1:0]     tgt_reg, tgt_next;
    logic                   inrange_reg, inrange_next;
    logic [CW-1:0]          scan_rd_reg, scan_rd_next;
    logic                   pend_reg, pend_next;
    logic [WORD_AW-1:0]     ev_word_reg, ev_word_next;
    logic                   res_ok_reg, res_ok_next;
    logic [FRAME_OUT_W-1:0] res_frame_reg, res_frame_next;
    logic [COUNT_W-1:0]     res_count_reg, res_count_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_ok_reg, m_ok_next;
    logic [FRAME_OUT_W-1:0] m_frame_out_reg, m_frame_out_next;
    logic [COUNT_W-1:0]     m_frames_used_reg, m_frames_used_next;

    logic                   mem_we, mem_re;
    logic [WORD_AW-1:0]     mem_wa, mem_ra;
    word_t                  mem_wd;

    logic [CW-1:0]          lim, nw, lim_word;
    logic [BIT_W-1:0]       lim_bits;
    word_t                  scan_mask, avail, rmw_bit;
    logic [BIT_W:0]         low;
    logic [ADDR_W-1:0]      addr_frame;
    logic                   fin, fin_ok;
    logic [FRAME_W-1:0]     fin_frame;

    always_comb begin
        lim = (CW'(frame_limit_reg) < CW'(NUM_FRAMES)) ? CW'(frame_limit_reg)
                                                       : CW'(NUM_FRAMES);
        nw       = (lim + CW'(WORD_BITS - 1)) >> BIT_W;
        lim_word = lim >> BIT_W;
        lim_bits = lim[BIT_W-1:0];
        if (CW'(ev_word_reg) < lim_word) begin
            scan_mask = '1;
        end else if (CW'(ev_word_reg) == lim_word) begin
            scan_mask = (word_t'(1) << lim_bits) - word_t'(1);
        end else begin
            scan_mask = '0;
        end
        avail      = ~rdata_reg & scan_mask;
        low        = find_low(avail);
        rmw_bit    = word_t'(1) << tgt_reg[BIT_W-1:0];
        addr_frame = s_phys_address >> PAGE_SHIFT;
    end

    always_comb begin
        state_next         = state_reg;
        clr_addr_next      = clr_addr_reg;
        frame_limit_next   = cfg_wr_en ? cfg_wr_data : frame_limit_reg;
        frames_used_next   = frames_used_reg;
        op_next            = op_reg;
        tgt_next           = tgt_reg;
        inrange_next       = inrange_reg;
        scan_rd_next       = scan_rd_reg;
        pend_next          = pend_reg;
        ev_word_next       = ev_word_reg;
        res_ok_next        = res_ok_reg;
        res_frame_next     = res_frame_reg;
        res_count_next     = res_count_reg;
        m_valid_next       = m_valid_reg;
        m_ok_next          = m_ok_reg;
        m_frame_out_next   = m_frame_out_reg;
        m_frames_used_next = m_frames_used_reg;
        mem_we             = 1'b0;
        mem_wa             = '0;
        mem_wd             = '0;
        mem_re             = 1'b0;
        mem_ra             = '0;
        fin                = 1'b0;
        fin_ok             = 1'b0;
        fin_frame          = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
                mem_wd = '0;
                if (clr_addr_reg == WORD_AW'(NUM_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + WORD_AW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next = s_func;
                    case (s_func)
                        FUNC_ALLOC: begin
                            scan_rd_next = '0;
                            pend_next    = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        FUNC_FREE: begin
                            tgt_next     = FRAME_W'(s_frame_index);
                            inrange_next = CW'(s_frame_index) < lim;
                            state_next   = ST_RMW_RD;
                        end
                        FUNC_MARK: begin
                            tgt_next     = FRAME_W'(addr_frame);
                            inrange_next = addr_frame < ADDR_W'(lim);
                            state_next   = ST_RMW_RD;
                        end
                        default: begin
                            inrange_next = 1'b0;
                            state_next   = ST_RMW_RD;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (pend_reg && low[BIT_W]) begin
                    mem_we           = 1'b1;
                    mem_wa           = ev_word_reg;
                    mem_wd           = rdata_reg | (word_t'(1) << low[BIT_W-1:0]);
                    frames_used_next = frames_used_reg + COUNT_W'(1);
                    fin              = 1'b1;
                    fin_ok           = 1'b1;
                    fin_frame        = {ev_word_reg, low[BIT_W-1:0]};
                end else if ((pend_reg && (CW'(ev_word_reg) + CW'(1) == nw))
                             || (!pend_reg && (scan_rd_reg >= nw))) begin
                    fin = 1'b1;
                end else if (scan_rd_reg < nw) begin
                    mem_re       = 1'b1;
                    mem_ra       = scan_rd_reg[WORD_AW-1:0];
                    scan_rd_next = scan_rd_reg + CW'(1);
                    pend_next    = 1'b1;
                    ev_word_next = scan_rd_reg[WORD_AW-1:0];
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_RMW_RD: begin
                if (inrange_reg) begin
                    mem_re     = 1'b1;
                    mem_ra     = tgt_reg[FRAME_W-1:BIT_W];
                    state_next = ST_RMW_EV;
                end else begin
                    fin = 1'b1;
                end
            end
            ST_RMW_EV: begin
                mem_we = 1'b1;
                mem_wa = tgt_reg[FRAME_W-1:BIT_W];
                if (op_reg == FUNC_FREE) begin
                    mem_wd = rdata_reg & ~rmw_bit;
                    if ((rdata_reg & rmw_bit) != '0) begin
                        frames_used_next = frames_used_reg - COUNT_W'(1);
                    end
                end else begin
                    mem_wd = rdata_reg | rmw_bit;
                    if ((rdata_reg & rmw_bit) == '0) begin
                        frames_used_next = frames_used_reg + COUNT_W'(1);
                    end
                end
                fin       = 1'b1;
                fin_ok    = 1'b1;
                fin_frame = tgt_reg;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_ok_next          = res_ok_reg;
                    m_frame_out_next   = res_frame_reg;
                    m_frames_used_next = res_count_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin) begin
            res_ok_next    = fin_ok;
            res_frame_next = fin_ok ? FRAME_OUT_W'(fin_frame) : '0;
            res_count_next = frames_used_next;
            state_next     = ST_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            frame_limit_reg <= LIMIT_RESET;
            frames_used_reg <= '0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            frame_limit_reg <= frame_limit_next;
            frames_used_reg <= frames_used_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
        end
        op_reg            <= op_next;
        tgt_reg           <= tgt_next;
        inrange_reg       <= inrange_next;
        scan_rd_reg       <= scan_rd_next;
        ev_word_reg       <= ev_word_next;
        res_ok_reg        <= res_ok_next;
        res_frame_reg     <= res_frame_next;
        res_count_reg     <= res_count_next;
        m_ok_reg          <= m_ok_next;
        m_frame_out_reg   <= m_frame_out_next;
        m_frames_used_reg <= m_frames_used_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_frame_out   = m_frame_out_reg;
    assign m_frames_used = m_frames_used_reg;

`ifndef SYNTHESIS
    a_rise_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result item appeared outside the done state");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_SCAN
                    || state_reg == ST_RMW_EV))
        else $error("map written outside a write state");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ok_reg) |-> (m_frame_out_reg == '0))
        else $error("failed item carries a nonzero frame");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (frames_used_reg != $past(frames_used_reg)))
        |-> (frames_used_reg == COUNT_W'($past(frames_used_reg) + COUNT_W'(1))
             || frames_used_reg == COUNT_W'($past(frames_used_reg) - COUNT_W'(1))))
        else $error("used count moved by more than one");
`endif

endmodule
